// File: src/wildcard_pattern_matcher_macros.svh
// ----------------------------------------------------------------------------
// Wildcard pattern matcher assertion macros
// Shared concurrent assertion forms; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_PATTERN_MATCHER_MACROS_SVH
`define WILDCARD_PATTERN_MATCHER_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define WPM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wildcard_pattern_matcher: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define WPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wildcard_pattern_matcher: assertion failed");

`else

`define WPM_ASSERT_IMPL(label, clk, rst, ante, cons)
`define WPM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: src/wpm_pkg.sv
// ----------------------------------------------------------------------------
// Wildcard pattern matcher package
// Sizes, command and register codes, character constants and shared types.
// ----------------------------------------------------------------------------
package wpm_pkg;

   // Pattern capacity, one cell per pattern character.
   localparam int MAX_PATTERN = 32;

   // Item commands.
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_CHAR   = 2'd2;
   localparam logic [1:0] CMD_END    = 2'd3;

   // Register port geometry and register indexes.
   localparam int REG_ADDR_W = 5;
   localparam int REG_DATA_W = 32;
   localparam logic [2:0] REG_CASE_FOLD     = 3'd0;
   localparam logic [2:0] REG_STAR_LITERAL  = 3'd1;
   localparam logic [2:0] REG_HASH_LITERAL  = 3'd2;
   localparam logic [2:0] REG_DOT_WILD_TAIL = 3'd3;
   localparam logic [2:0] REG_PREFIX_ACCEPT = 3'd4;
   localparam logic [2:0] REG_SPACE_ENDS    = 3'd5;

   // Characters with a special meaning.
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   // Matching options.
   typedef struct packed {
      logic case_fold;
      logic star_literal;
      logic hash_literal;
      logic dot_wild_tail;
      logic prefix_accept;
      logic space_ends_pattern;
   } cfg_type;

   // Per-item controls broadcast to every cell.
   typedef struct packed {
      logic       clear;
      logic       append;
      logic       take;
      logic       restart;
      logic [7:0] ch;
   } cell_ctl_type;

   // Signals that ripple combinationally from one cell to the next.
   typedef struct packed {
      logic carry_a;   // star closure before the character
      logic adv;       // position advanced by the character
      logic carry_b;   // star closure after the character
   } link_type;

   // Per-cell acceptance terms.
   typedef struct packed {
      logic hit_a;     // live end position before the character
      logic hit_b;     // live end position after the character
      logic dot_hit;   // live trailing dot consumed a character
   } cell_stat_type;

   // One result item.
   typedef struct packed {
      logic matched;
      logic pattern_overflow;
   } result_type;

   // Folds an upper-case ASCII letter to lower case when enabled.
   function automatic logic [7:0] fold_case(input logic [7:0] c, input logic en);
      logic [7:0] r;
      r = c;
      if (en && (c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

// File: src/wildcard_pattern_matcher.sv
// ----------------------------------------------------------------------------
// Wildcard pattern matcher
// Glob matcher over a stored pattern, built as a row of pattern cells that
// track every live pattern position in parallel.
//
//   Channel   Direction  Handshake             Payload
//   req       in         req_valid/req_stall   req_cmd, req_ch
//   rsp       out        rsp_valid/rsp_stall   rsp_matched, rsp_pattern_overflow
//   config    in         psel/penable/pready   paddr, pwdata, prdata
//
// One item is taken every cycle while req_stall is low. A result is registered
// in the output register, or in the skid entry while that register is stalled.
// Each character step runs the star-closure ripple through the cell row twice.
// Reset is synchronous and leaves an empty pattern with only position zero live.
// req_stall rises only when the output register and the skid entry are both full.
// ----------------------------------------------------------------------------
`include "wildcard_pattern_matcher_macros.svh"

module wildcard_pattern_matcher (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_cmd,
   input  logic [7:0]                     req_ch,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_matched,
   output logic                           rsp_pattern_overflow,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [wpm_pkg::REG_ADDR_W-1:0] paddr,
   input  logic [wpm_pkg::REG_DATA_W-1:0] pwdata,
   output logic [wpm_pkg::REG_DATA_W-1:0] prdata,
   output logic                           pready
);

   localparam int NCELL = wpm_pkg::MAX_PATTERN;

   wpm_pkg::cfg_type       cfg;
   wpm_pkg::cell_ctl_type  ctl;
   wpm_pkg::link_type      links [0:NCELL];
   wpm_pkg::cell_stat_type stats [0:NCELL-1];
   wpm_pkg::result_type    result;
   wpm_pkg::result_type    rsp_data;

   logic [NCELL:0]   fill_vec;
   logic [NCELL-1:0] fill_left;
   logic [NCELL-1:0] hit_a_vec;
   logic [NCELL-1:0] hit_b_vec;
   logic [NCELL-1:0] dot_vec;

   logic accept;
   logic full;
   logic push;
   logic live_end_ff;
   logic live_end_in;
   logic accept_ff;
   logic accept_in;
   logic overflow_ff;
   logic overflow_in;
   logic end_a;
   logic end_b;
   logic any_a;
   logic any_b;

   // Option registers.
   wpm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Item acceptance and per-cell controls.
   assign req_stall = full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      ctl.clear   = accept && (req_cmd == wpm_pkg::CMD_CLEAR);
      ctl.append  = accept && (req_cmd == wpm_pkg::CMD_APPEND);
      ctl.take    = accept && (req_cmd == wpm_pkg::CMD_CHAR);
      ctl.restart = accept && (req_cmd != wpm_pkg::CMD_CHAR);
      ctl.ch      = req_ch;
   end

   // Row of cells; nothing enters the first cell from the left.
   assign links[0]         = '0;
   assign fill_vec[NCELL]  = 1'b0;
   assign fill_left        = {fill_vec[NCELL-2:0], 1'b1};

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      wpm_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .cfg          (cfg),
         .ctl          (ctl),
         .live_init    (i == 0),
         .left_filled  (fill_left[i]),
         .right_filled (fill_vec[i+1]),
         .left         (links[i]),
         .right        (links[i+1]),
         .filled       (fill_vec[i]),
         .stat         (stats[i])
      );
      assign hit_a_vec[i] = stats[i].hit_a;
      assign hit_b_vec[i] = stats[i].hit_b;
      assign dot_vec[i]   = stats[i].dot_hit;
   end

   // Position past the last cell is always an end position.
   assign end_a = live_end_ff || links[NCELL].carry_a;
   assign end_b = links[NCELL].adv || links[NCELL].carry_b;
   assign any_a = (|hit_a_vec) || end_a;
   assign any_b = (|hit_b_vec) || end_b;

   // Match state and overflow flag.
   always_comb begin
      live_end_in = live_end_ff;
      accept_in   = accept_ff;
      overflow_in = overflow_ff;
      if (accept) begin
         case (req_cmd)
            wpm_pkg::CMD_CLEAR: begin
               live_end_in = 1'b0;
               accept_in   = 1'b0;
               overflow_in = 1'b0;
            end
            wpm_pkg::CMD_APPEND: begin
               live_end_in = 1'b0;
               accept_in   = 1'b0;
               if (fill_vec[NCELL-1]) begin
                  overflow_in = 1'b1;
               end
            end
            wpm_pkg::CMD_CHAR: begin
               live_end_in = end_b;
               accept_in   = accept_ff || (|dot_vec) ||
                             (cfg.prefix_accept && (any_a || any_b));
            end
            default: begin
               live_end_in = 1'b0;
               accept_in   = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_end_ff <= 1'b0;
         accept_ff   <= 1'b0;
         overflow_ff <= 1'b0;
      end else begin
         live_end_ff <= live_end_in;
         accept_ff   <= accept_in;
         overflow_ff <= overflow_in;
      end
   end

   // Result of an end-of-string item.
   assign push                    = accept && (req_cmd == wpm_pkg::CMD_END);
   assign result.matched          = accept_ff || any_a;
   assign result.pattern_overflow = overflow_ff;

   wpm_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_matched          = rsp_data.matched;
   assign rsp_pattern_overflow = rsp_data.pattern_overflow;

   // Filled cells always form an unbroken run from the first cell.
   `WPM_ASSERT_IMPL(a_fill_contiguous, clock, reset, 1'b1, ((fill_vec >> 1) & ~fill_vec) == '0)
   // Overflow can only be flagged while the pattern is full.
   `WPM_ASSERT_IMPL(a_overflow_full, clock, reset, overflow_ff, fill_vec[NCELL-1])
   // After every end-of-string item a result is waiting in the next cycle.
   `WPM_ASSERT_NEXT(a_end_gives_result, clock, reset, push, rsp_valid)

endmodule

// File: src/wpm_cell.sv
// ----------------------------------------------------------------------------
// Wildcard pattern matcher cell
// Holds one pattern character, its fill bit and the live bit of its position.
// ----------------------------------------------------------------------------
module wpm_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  wpm_pkg::cfg_type       cfg,
   input  wpm_pkg::cell_ctl_type  ctl,
   input  logic                   live_init,
   input  logic                   left_filled,
   input  logic                   right_filled,
   input  wpm_pkg::link_type      left,
   output wpm_pkg::link_type      right,
   output logic                   filled,
   output wpm_pkg::cell_stat_type stat
);

   logic [7:0] char_ff;
   logic       filled_ff;
   logic       filled_in;
   logic       live_ff;
   logic       live_in;

   logic       write_en;
   logic       is_end;
   logic       is_dot_tail;
   logic       is_star;
   logic       is_plain;
   logic       char_match;
   logic       live_a;
   logic       live_next;
   logic       live_b;

   // This cell takes an appended character when it is the first empty one.
   assign write_en = ctl.append && left_filled && !filled_ff;

   // Role of this position under the current options.
   always_comb begin
      is_end = !filled_ff ||
               (cfg.space_ends_pattern && (char_ff == wpm_pkg::CH_SPACE)) ||
               (cfg.prefix_accept && cfg.dot_wild_tail && (char_ff == wpm_pkg::CH_DOT));
      is_dot_tail = !is_end && cfg.dot_wild_tail && (char_ff == wpm_pkg::CH_DOT) &&
                    !right_filled;
      is_star  = !is_end && !is_dot_tail && !cfg.star_literal &&
                 (char_ff == wpm_pkg::CH_STAR);
      is_plain = !is_end && !is_dot_tail && !is_star;
      char_match = (!cfg.hash_literal && (char_ff == wpm_pkg::CH_HASH)) ||
                   (wpm_pkg::fold_case(char_ff, cfg.case_fold) ==
                    wpm_pkg::fold_case(ctl.ch, cfg.case_fold));
   end

   // Close over stars, step on the character, then close over stars again.
   always_comb begin
      live_a        = live_ff || left.carry_a;
      right.carry_a = live_a && is_star;
      right.adv     = live_a && is_plain && char_match;
      live_next     = left.adv || (live_a && is_star);
      live_b        = live_next || left.carry_b;
      right.carry_b = live_b && is_star;
      stat.hit_a    = live_a && is_end;
      stat.hit_b    = live_b && is_end;
      stat.dot_hit  = live_a && is_dot_tail;
   end

   // Next fill and live state.
   always_comb begin
      filled_in = filled_ff;
      if (ctl.clear) begin
         filled_in = 1'b0;
      end else if (write_en) begin
         filled_in = 1'b1;
      end
      live_in = live_ff;
      if (ctl.restart) begin
         live_in = live_init;
      end else if (ctl.take) begin
         live_in = live_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= 1'b0;
         live_ff   <= live_init;
      end else begin
         filled_ff <= filled_in;
         live_ff   <= live_in;
      end
   end

   // Pattern character storage.
   always_ff @(posedge clock) begin
      if (write_en) begin
         char_ff <= ctl.ch;
      end
   end

   assign filled = filled_ff;

endmodule

// File: src/wpm_csr.sv
// ----------------------------------------------------------------------------
// Wildcard pattern matcher registers
// Option registers behind a simple APB-style slave port.
// ----------------------------------------------------------------------------
module wpm_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [wpm_pkg::REG_ADDR_W-1:0] paddr,
   input  logic [wpm_pkg::REG_DATA_W-1:0] pwdata,
   output logic [wpm_pkg::REG_DATA_W-1:0] prdata,
   output logic                           pready,
   output wpm_pkg::cfg_type               cfg
);

   wpm_pkg::cfg_type cfg_ff;
   wpm_pkg::cfg_type cfg_in;
   logic [2:0]       reg_index;
   logic             wr_en;
   logic             rd_bit;

   assign pready    = 1'b1;
   assign reg_index = paddr[wpm_pkg::REG_ADDR_W-1:2];
   assign wr_en     = psel && penable && pwrite && pready;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            wpm_pkg::REG_CASE_FOLD:     cfg_in.case_fold          = pwdata[0];
            wpm_pkg::REG_STAR_LITERAL:  cfg_in.star_literal       = pwdata[0];
            wpm_pkg::REG_HASH_LITERAL:  cfg_in.hash_literal       = pwdata[0];
            wpm_pkg::REG_DOT_WILD_TAIL: cfg_in.dot_wild_tail      = pwdata[0];
            wpm_pkg::REG_PREFIX_ACCEPT: cfg_in.prefix_accept      = pwdata[0];
            wpm_pkg::REG_SPACE_ENDS:    cfg_in.space_ends_pattern = pwdata[0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register read mux.
   always_comb begin
      case (reg_index)
         wpm_pkg::REG_CASE_FOLD:     rd_bit = cfg_ff.case_fold;
         wpm_pkg::REG_STAR_LITERAL:  rd_bit = cfg_ff.star_literal;
         wpm_pkg::REG_HASH_LITERAL:  rd_bit = cfg_ff.hash_literal;
         wpm_pkg::REG_DOT_WILD_TAIL: rd_bit = cfg_ff.dot_wild_tail;
         wpm_pkg::REG_PREFIX_ACCEPT: rd_bit = cfg_ff.prefix_accept;
         wpm_pkg::REG_SPACE_ENDS:    rd_bit = cfg_ff.space_ends_pattern;
         default:                    rd_bit = 1'b0;
      endcase
   end

   assign prdata = {{(wpm_pkg::REG_DATA_W-1){1'b0}}, rd_bit};
   assign cfg    = cfg_ff;

endmodule

// File: src/wpm_out_buf.sv
// ----------------------------------------------------------------------------
// Wildcard pattern matcher result buffer
// Output register plus one skid entry, so the input side never waits on a
// combinational path from the result stall.
// ----------------------------------------------------------------------------
`include "wildcard_pattern_matcher_macros.svh"

module wpm_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  wpm_pkg::result_type push_data,
   output logic                full,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output wpm_pkg::result_type rsp_data
);

   logic                out_valid_ff;
   logic                out_valid_in;
   logic                skid_valid_ff;
   logic                skid_valid_in;
   wpm_pkg::result_type out_data_ff;
   wpm_pkg::result_type skid_data_ff;
   logic                out_free;

   assign out_free = !out_valid_ff || !rsp_stall;

   // Valid bits: the skid entry drains first, new items land behind it.
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         out_valid_in  = skid_valid_ff || push;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (out_free) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : push_data;
      end else if (push) begin
         skid_data_ff <= push_data;
      end
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // A new item never arrives while the skid entry is occupied.
   `WPM_ASSERT_IMPL(a_no_push_when_full, clock, reset, push, !skid_valid_ff)
   // The skid entry is only used behind a waiting result.
   `WPM_ASSERT_IMPL(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Wildcard pattern matcher testbench
// Loads patterns, streams strings and checks every match verdict against a
// cycle-free predictor of the glob rules. The test runs directed cases first,
// then a long output hold-off, then random pattern and string sequences under
// several option settings. Both channels see random idle and stall cycles.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 4;
   localparam logic [7:0] CHAR_POOL [10] = '{
      8'h61, 8'h62, 8'h41, 8'h42, wpm_pkg::CH_STAR, wpm_pkg::CH_HASH,
      wpm_pkg::CH_DOT, wpm_pkg::CH_SPACE, 8'h5A, 8'h7A
   };

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic [1:0]                     req_cmd;
   logic [7:0]                     req_ch;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic                           rsp_matched;
   logic                           rsp_pattern_overflow;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [wpm_pkg::REG_ADDR_W-1:0] paddr;
   logic [wpm_pkg::REG_DATA_W-1:0] pwdata;
   logic [wpm_pkg::REG_DATA_W-1:0] prdata;
   logic                           pready;

   // Predictor state: stored pattern, live positions and option bits.
   logic [7:0]                     pat_mem [wpm_pkg::MAX_PATTERN];
   int                             pat_len;
   logic [wpm_pkg::MAX_PATTERN:0]  live;
   bit                             accept_hold;
   bit                             ovf_seen;
   wpm_pkg::cfg_type               opts;

   wpm_pkg::result_type            pending_verdicts [$];
   int                             err_count;
   int                             items_sent;
   int                             idle_cycles;
   int                             rsp_hold_cycles;
   bit                             req_gaps_on;
   bit                             rsp_gaps_on;

   wildcard_pattern_matcher uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_cmd              (req_cmd),
      .req_ch               (req_ch),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_matched          (rsp_matched),
      .rsp_pattern_overflow (rsp_pattern_overflow),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   always #5 clock = ~clock;

   // Error reporting: the first few in full, the rest only counted.
   task automatic note_error(input string msg);
      err_count++;
      if (err_count <= 10) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
   endtask

   // ASCII upper-case letters gain bit 5 when case folding is on.
   function automatic logic [7:0] cmp_char(input logic [7:0] c);
      logic upper;
      upper = (c >= wpm_pkg::CH_UPPER_A) && (c <= wpm_pkg::CH_UPPER_Z);
      return {c[7:6], c[5] | (upper & opts.case_fold), c[4:0]};
   endfunction

   // A position where the pattern counts as used up.
   function automatic bit pos_ends(input int i);
      if (i >= pat_len) begin
         return 1'b1;
      end
      if (opts.space_ends_pattern && pat_mem[i] == wpm_pkg::CH_SPACE) begin
         return 1'b1;
      end
      return opts.prefix_accept && opts.dot_wild_tail && pat_mem[i] == wpm_pkg::CH_DOT;
   endfunction

   function automatic bit pos_dot_tail(input int i);
      return !pos_ends(i) && opts.dot_wild_tail && pat_mem[i] == wpm_pkg::CH_DOT &&
             (i + 1 == pat_len);
   endfunction

   function automatic bit pos_star(input int i);
      return !pos_ends(i) && !pos_dot_tail(i) && !opts.star_literal &&
             pat_mem[i] == wpm_pkg::CH_STAR;
   endfunction

   // Stars may match an empty run, so a live star also makes the next position
   // live; the sweep runs upward so chains of stars close in one pass.
   function automatic void close_stars();
      for (int i = 0; i < pat_len; i++) begin
         if (live[i] && pos_star(i)) begin
            live[i + 1] = 1'b1;
         end
      end
      if (opts.prefix_accept) begin
         for (int i = 0; i <= pat_len; i++) begin
            if (live[i] && pos_ends(i)) begin
               accept_hold = 1'b1;
            end
         end
      end
   endfunction

   function automatic void restart_text();
      live = '0;
      live[0] = 1'b1;
      accept_hold = 1'b0;
   endfunction

   // Advance every live position over one string character.
   function automatic void consume_char(input logic [7:0] c);
      logic [wpm_pkg::MAX_PATTERN:0] nxt;
      logic [7:0]                    p;
      close_stars();
      nxt = '0;
      for (int i = 0; i < pat_len; i++) begin
         if (live[i] && !pos_ends(i)) begin
            p = pat_mem[i];
            if (pos_dot_tail(i)) begin
               accept_hold = 1'b1;
            end else if (pos_star(i)) begin
               nxt[i] = 1'b1;
            end else if ((p == wpm_pkg::CH_HASH && !opts.hash_literal) ||
                         cmp_char(p) == cmp_char(c)) begin
               nxt[i + 1] = 1'b1;
            end
         end
      end
      live = nxt;
      close_stars();
   endfunction

   function automatic bit text_matches();
      close_stars();
      if (accept_hold) begin
         return 1'b1;
      end
      for (int i = 0; i <= pat_len; i++) begin
         if (live[i] && pos_ends(i)) begin
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Apply one accepted item to the predictor and queue its verdict, if any.
   function automatic void track_item(input logic [1:0] cmd, input logic [7:0] ch);
      wpm_pkg::result_type verdict;
      case (cmd)
         wpm_pkg::CMD_CLEAR: begin
            pat_len = 0;
            ovf_seen = 1'b0;
            restart_text();
         end
         wpm_pkg::CMD_APPEND: begin
            if (pat_len < wpm_pkg::MAX_PATTERN) begin
               pat_mem[pat_len] = ch;
               pat_len++;
            end else begin
               ovf_seen = 1'b1;
            end
            restart_text();
         end
         wpm_pkg::CMD_CHAR: begin
            consume_char(ch);
         end
         default: begin
            verdict.matched = text_matches();
            verdict.pattern_overflow = ovf_seen;
            pending_verdicts.push_back(verdict);
            restart_text();
         end
      endcase
   endfunction

   // Idle run lengths: mostly short, a few long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] rand_char();
      if ($urandom_range(0, 99) < 60) begin
         return CHAR_POOL[$urandom_range(0, 9)];
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // Offer one item and hold it until the block takes it.
   task automatic send_item(input logic [1:0] cmd, input logic [7:0] ch);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_ch    <= ch;
      do @(posedge clock); while (req_stall);
      track_item(cmd, ch);
      items_sent++;
   endtask

   // Stop offering items and let every verdict and the tail of the pipe drain.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_verdicts.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register write followed by a read back of the same register.
   task automatic write_reg(input logic [2:0] idx, input logic v);
      logic [wpm_pkg::REG_DATA_W-1:0] value;
      value = wpm_pkg::REG_DATA_W'(v);
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      pwrite  <= 1'b1;
      psel    <= 1'b1;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== value) begin
         note_error($sformatf("register %0d read %0h, wrote %0h", idx, prdata, value));
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic apply_options(input wpm_pkg::cfg_type v);
      wait_idle();
      write_reg(wpm_pkg::REG_CASE_FOLD, v.case_fold);
      write_reg(wpm_pkg::REG_STAR_LITERAL, v.star_literal);
      write_reg(wpm_pkg::REG_HASH_LITERAL, v.hash_literal);
      write_reg(wpm_pkg::REG_DOT_WILD_TAIL, v.dot_wild_tail);
      write_reg(wpm_pkg::REG_PREFIX_ACCEPT, v.prefix_accept);
      write_reg(wpm_pkg::REG_SPACE_ENDS, v.space_ends_pattern);
      opts = v;
   endtask

   // A new pattern, usually after a clear; sometimes long enough to overflow.
   task automatic send_pattern();
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (r < 65) begin
         n = $urandom_range(0, 5);
      end else if (r < 92) begin
         n = $urandom_range(6, 14);
      end else begin
         n = $urandom_range(29, 36);
      end
      if ($urandom_range(0, 7) != 0) begin
         send_item(wpm_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
      end
      repeat (n) send_item(wpm_pkg::CMD_APPEND, rand_char());
   endtask

   // One string, mostly shaped after the stored pattern so that matches are
   // common, then sometimes damaged at one spot.
   task automatic send_text();
      logic [7:0] txt [$];
      logic [7:0] p;
      int         r;
      if ($urandom_range(0, 3) != 0) begin
         for (int i = 0; i < pat_len; i++) begin
            p = pat_mem[i];
            if (p == wpm_pkg::CH_STAR) begin
               repeat ($urandom_range(0, 3)) txt.push_back(rand_char());
            end else if (p == wpm_pkg::CH_HASH) begin
               txt.push_back(rand_char());
            end else if ((p | 8'h20) >= 8'h61 && (p | 8'h20) <= 8'h7A &&
                         $urandom_range(0, 1) == 1) begin
               txt.push_back(p ^ 8'h20);
            end else begin
               txt.push_back(p);
            end
         end
      end else begin
         repeat ($urandom_range(0, 8)) txt.push_back(rand_char());
      end
      r = $urandom_range(0, 7);
      if (r == 0 && txt.size() > 0) begin
         void'(txt.pop_back());
      end else if (r == 1) begin
         txt.push_back(rand_char());
      end else if (r == 2 && txt.size() > 0) begin
         txt[$urandom_range(0, txt.size() - 1)] = rand_char();
      end
      foreach (txt[k]) send_item(wpm_pkg::CMD_CHAR, txt[k]);
      send_item(wpm_pkg::CMD_END, 8'($urandom_range(0, 255)));
   endtask

   // Default options: star, hash, empty strings, empty pattern, zero bytes.
   task automatic test_plain_glob();
      send_item(wpm_pkg::CMD_CLEAR, 8'h00);
      send_item(wpm_pkg::CMD_APPEND, "a");
      send_item(wpm_pkg::CMD_APPEND, "*");
      send_item(wpm_pkg::CMD_APPEND, "#");
      send_item(wpm_pkg::CMD_CHAR, "a");
      send_item(wpm_pkg::CMD_CHAR, 8'hFF);
      send_item(wpm_pkg::CMD_CHAR, 8'h00);
      send_item(wpm_pkg::CMD_END, 8'hFF);
      send_item(wpm_pkg::CMD_END, 8'h00);
      // A hash must not match past the end of the string.
      send_item(wpm_pkg::CMD_CHAR, "a");
      send_item(wpm_pkg::CMD_END, 8'h00);
      send_item(wpm_pkg::CMD_CLEAR, 8'hFF);
      send_item(wpm_pkg::CMD_END, 8'h00);
      send_item(wpm_pkg::CMD_CHAR, 8'h00);
      send_item(wpm_pkg::CMD_END, 8'h00);
   endtask

   // Every option on: folded case, literal star and hash, dot ends the pattern.
   task automatic test_all_options();
      apply_options('1);
      send_item(wpm_pkg::CMD_CLEAR, 8'h00);
      send_item(wpm_pkg::CMD_APPEND, "X");
      send_item(wpm_pkg::CMD_APPEND, "*");
      send_item(wpm_pkg::CMD_APPEND, "#");
      send_item(wpm_pkg::CMD_APPEND, ".");
      send_item(wpm_pkg::CMD_CHAR, "x");
      send_item(wpm_pkg::CMD_CHAR, "*");
      send_item(wpm_pkg::CMD_CHAR, "#");
      send_item(wpm_pkg::CMD_END, 8'h00);
      send_item(wpm_pkg::CMD_CHAR, "x");
      send_item(wpm_pkg::CMD_CHAR, "q");
      send_item(wpm_pkg::CMD_END, 8'h00);
   endtask

   // The receiver holds off for a long stretch while items keep coming, so the
   // block fills and stalls its input.
   task automatic test_output_hold();
      apply_options('0);
      req_gaps_on = 1'b0;
      rsp_hold_cycles = 240;
      send_item(wpm_pkg::CMD_CLEAR, 8'h00);
      send_item(wpm_pkg::CMD_APPEND, "a");
      send_item(wpm_pkg::CMD_APPEND, "#");
      repeat (12) begin
         send_item(wpm_pkg::CMD_CHAR, "a");
         send_item(wpm_pkg::CMD_CHAR, rand_char());
         send_item(wpm_pkg::CMD_END, 8'h00);
      end
      req_gaps_on = 1'b1;
   endtask

   // Random sequences under a series of option settings.
   task automatic test_random_phases();
      wpm_pkg::cfg_type v;
      int               start;
      int               r;
      for (int phase = 0; phase < 9; phase++) begin
         case (phase)
            0:       v = '0;
            1:       v = '1;
            2:       v = '{dot_wild_tail: 1'b1, default: 1'b0};
            default: v = 6'($urandom_range(0, 63));
         endcase
         apply_options(v);
         req_gaps_on = (phase == 0) || ($urandom_range(0, 3) != 0);
         rsp_gaps_on = (phase == 0) || ($urandom_range(0, 3) != 0);
         start = items_sent;
         while (items_sent - start < 90) begin
            r = $urandom_range(0, 99);
            if (r < 18 || (pat_len == 0 && r < 50)) begin
               send_pattern();
            end else if (r < 90) begin
               send_text();
            end else begin
               send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
         end
      end
      rsp_gaps_on = 1'b1;
   endtask

   // Main sequence.
   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_cmd   <= wpm_pkg::CMD_CLEAR;
      req_ch    <= 8'h00;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= '0;
      pwdata    <= '0;
      for (int i = 0; i < wpm_pkg::MAX_PATTERN; i++) begin
         pat_mem[i] = 8'h00;
      end
      pat_len = 0;
      ovf_seen = 1'b0;
      opts = '0;
      restart_text();
      err_count = 0;
      items_sent = 0;
      rsp_hold_cycles = 0;
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_plain_glob();
      test_all_options();
      test_output_hold();
      test_random_phases();

      req_valid <= 1'b0;
      while (pending_verdicts.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (pending_verdicts.size() != 0) begin
         note_error($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
      end
      if (err_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Receiver stalls: alternating open and stalled runs, plus the long hold.
   initial begin
      int open_run;
      int stall_run;
      open_run = 0;
      stall_run = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold_cycles--;
         end else if (stall_run > 0) begin
            rsp_stall <= 1'b1;
            stall_run--;
         end else if (open_run > 0 || !rsp_gaps_on) begin
            rsp_stall <= 1'b0;
            if (open_run > 0) begin
               open_run--;
            end
         end else begin
            rsp_stall <= 1'b0;
            open_run  = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6)
                                                      : $urandom_range(20, 60);
            stall_run = ($urandom_range(0, 99) < 88) ? $urandom_range(1, 3)
                                                      : $urandom_range(12, 40);
         end
      end
   end

   // Verdict checker: each result against the oldest expectation.
   always @(posedge clock) begin
      wpm_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            note_error($sformatf("unexpected result matched=%0b overflow=%0b",
                                 rsp_matched, rsp_pattern_overflow));
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_matched !== want.matched) begin
               note_error($sformatf("matched expected %0b got %0b",
                                    want.matched, rsp_matched));
            end
            if (rsp_pattern_overflow !== want.pattern_overflow) begin
               note_error($sformatf("pattern_overflow expected %0b got %0b",
                                    want.pattern_overflow, rsp_pattern_overflow));
            end
         end
      end
   end

   // Watchdog on cycles with no handshake on any port.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", idle_cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule
